>>> design/sle_pkg.sv
package sle_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;

    localparam logic [2:0] ACT_FILL   = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_FIND   = 3'd3;
    localparam logic [2:0] ACT_GET    = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_FILL   = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_DELETE = 2'd3
    } t_cell_op;

    // one-cycle update broadcast to every cell
    typedef struct packed {
        t_cell_op          op;
        logic [IDX_W-1:0]  index;
        logic [CNT_W-1:0]  bound;
        logic [31:0]       value;
    } t_cmd;

    // held while a token walks the row
    typedef struct packed {
        logic              find;
        logic [IDX_W-1:0]  index;
        logic [CNT_W-1:0]  bound;
        logic [31:0]       key;
    } t_probe;

    typedef struct packed {
        logic              vld;
        logic              hit;
        logic [CNT_W-1:0]  pos;
        logic [31:0]       data;
    } t_token;

endpackage

>>> design/sle_in_if.sv
interface sle_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [7:0]         position;
    logic signed [31:0] value;
    logic [7:0]         fill_count;

    modport source (output valid, output action, output position, output value,
                    output fill_count, input ready);
    modport sink (input valid, input action, input position, input value,
                  input fill_count, output ready);
endinterface

>>> design/sle_out_if.sv
interface sle_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [7:0]         found_position;
    logic [7:0]         list_length;

    modport source (output valid, output status, output data, output found_position,
                    output list_length, input ready);
    modport sink (input valid, input status, input data, input found_position,
                  input list_length, output ready);
endinterface

>>> design/sle_cell.sv
module sle_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [sle_pkg::IDX_W-1:0]  i_index,
    input  sle_pkg::t_cmd              i_cmd,
    input  sle_pkg::t_probe            i_probe,
    input  logic [31:0]                i_left,
    input  logic [31:0]                i_right,
    input  sle_pkg::t_token            i_tok,
    output logic [31:0]                o_entry,
    output sle_pkg::t_token            o_tok
);

    logic [31:0]                r_entry;
    logic [31:0]                n_entry;
    sle_pkg::t_token            r_tok;
    sle_pkg::t_token            n_tok;
    logic [sle_pkg::CNT_W-1:0]  w_idx;

    assign w_idx = sle_pkg::CNT_W'(i_index);

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            sle_pkg::CELL_FILL: begin
                if (w_idx < i_cmd.bound) begin
                    n_entry = 32'(i_index);
                end
            end
            sle_pkg::CELL_INSERT: begin
                if (i_index == i_cmd.index) begin
                    n_entry = i_cmd.value;
                end else if (i_index > i_cmd.index && w_idx <= i_cmd.bound) begin
                    n_entry = i_left;
                end
            end
            sle_pkg::CELL_DELETE: begin
                if (i_index >= i_cmd.index &&
                    (w_idx + sle_pkg::CNT_W'(1)) < i_cmd.bound) begin
                    n_entry = i_right;
                end
            end
            sle_pkg::CELL_HOLD: begin
                n_entry = r_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld) begin
            if (i_probe.find) begin
                if (!i_tok.hit && w_idx < i_probe.bound && r_entry == i_probe.key) begin
                    n_tok.hit = 1'b1;
                    n_tok.pos = w_idx + sle_pkg::CNT_W'(1);
                end
            end else if (i_index == i_probe.index) begin
                n_tok.hit  = 1'b1;
                n_tok.data = r_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_entry = r_entry;
    assign o_tok   = r_tok;

endmodule

>>> design/sequential_list_engine_top.sv
// Fill, insert and rejected items: result in the cycle after the input transfer.
// Delete, find and get: a token walks the row of CAPACITY cells one cell per cycle,
// and the result is taken when the token leaves the last cell.
// One item in flight; input ready again the cycle after the result transfer.
// Reset (i_rst_n low, synchronous) empties the list and clears control;
// cell entries are not cleared.
module sequential_list_engine_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sle_in_if.sink    i_in,
    sle_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    logic [sle_pkg::CNT_W-1:0]  r_count;
    logic [sle_pkg::CNT_W-1:0]  n_count;
    sle_pkg::t_cmd              r_cmd;
    sle_pkg::t_cmd              n_cmd;
    sle_pkg::t_probe            r_probe;
    sle_pkg::t_probe            n_probe;
    logic                       r_launch;
    logic                       n_launch;
    logic [2:0]                 r_act;
    logic [2:0]                 n_act;
    logic [1:0]                 r_status;
    logic [1:0]                 n_status;
    logic [31:0]                r_data;
    logic [31:0]                n_data;
    logic [7:0]                 r_found;
    logic [7:0]                 n_found;

    logic [31:0]                w_entry [sle_pkg::CAPACITY];
    logic [31:0]                w_left  [sle_pkg::CAPACITY];
    logic [31:0]                w_right [sle_pkg::CAPACITY];
    sle_pkg::t_token            w_tok   [sle_pkg::CAPACITY];
    sle_pkg::t_token            w_tin   [sle_pkg::CAPACITY];
    sle_pkg::t_token            w_tok_in;
    sle_pkg::t_token            w_tok_last;

    logic [sle_pkg::CMP_W-1:0]  w_pos;
    logic [sle_pkg::CMP_W-1:0]  w_fill;
    logic [sle_pkg::CMP_W-1:0]  w_count;
    logic [sle_pkg::CMP_W-1:0]  w_cap;
    logic [sle_pkg::CMP_W-1:0]  w_found_ext;
    logic                       w_in_acc;

    assign w_pos       = sle_pkg::CMP_W'(i_in.position);
    assign w_fill      = sle_pkg::CMP_W'(i_in.fill_count);
    assign w_count     = sle_pkg::CMP_W'(r_count);
    assign w_cap       = sle_pkg::CMP_W'(sle_pkg::CAPACITY);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_tok_last  = w_tok[sle_pkg::CAPACITY-1];
    assign w_found_ext = sle_pkg::CMP_W'(w_tok_last.pos);

    always_comb begin
        w_tok_in     = '0;
        w_tok_in.vld = r_launch;
    end

    for (genvar g = 0; g < sle_pkg::CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = '0;
            assign w_tin[g]  = w_tok_in;
        end else begin : g_body
            assign w_left[g] = w_entry[g-1];
            assign w_tin[g]  = w_tok[g-1];
        end
        if (g == sle_pkg::CAPACITY - 1) begin : g_tail
            assign w_right[g] = '0;
        end else begin : g_mid
            assign w_right[g] = w_entry[g+1];
        end

        sle_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (sle_pkg::IDX_W'(g)),
            .i_cmd   (r_cmd),
            .i_probe (r_probe),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_tok   (w_tin[g]),
            .o_entry (w_entry[g]),
            .o_tok   (w_tok[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cmd    = r_cmd;
        n_cmd.op = sle_pkg::CELL_HOLD;
        n_probe  = r_probe;
        n_launch = 1'b0;
        n_act    = r_act;
        n_status = r_status;
        n_data   = r_data;
        n_found  = r_found;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_act    = i_in.action;
                    n_status = sle_pkg::ST_OK;
                    n_data   = '0;
                    n_found  = '0;
                    n_state  = S_OUT;
                    case (i_in.action)
                        sle_pkg::ACT_FILL: begin
                            if (w_fill > w_cap) begin
                                n_status = sle_pkg::ST_BAD;
                            end else begin
                                n_cmd.op    = sle_pkg::CELL_FILL;
                                n_cmd.bound = sle_pkg::CNT_W'(w_fill);
                                n_count     = sle_pkg::CNT_W'(w_fill);
                            end
                        end
                        sle_pkg::ACT_INSERT: begin
                            if (w_pos == '0 || w_pos > w_cap) begin
                                n_status = sle_pkg::ST_BAD;
                            end else if (w_count == w_cap) begin
                                n_status = sle_pkg::ST_FULL;
                            end else begin
                                n_cmd.op    = sle_pkg::CELL_INSERT;
                                n_cmd.index = (w_pos > w_count) ?
                                              sle_pkg::IDX_W'(w_count) :
                                              sle_pkg::IDX_W'(w_pos - sle_pkg::CMP_W'(1));
                                n_cmd.bound = r_count;
                                n_cmd.value = i_in.value;
                                n_count     = r_count + sle_pkg::CNT_W'(1);
                            end
                        end
                        sle_pkg::ACT_DELETE, sle_pkg::ACT_GET: begin
                            if (w_pos == '0 || w_pos > w_count) begin
                                n_status = sle_pkg::ST_BAD;
                            end else begin
                                n_probe.find  = 1'b0;
                                n_probe.index = sle_pkg::IDX_W'(w_pos - sle_pkg::CMP_W'(1));
                                n_probe.bound = r_count;
                                n_launch      = 1'b1;
                                n_state       = S_WALK;
                            end
                        end
                        sle_pkg::ACT_FIND: begin
                            n_probe.find  = 1'b1;
                            n_probe.key   = i_in.value;
                            n_probe.bound = r_count;
                            n_launch      = 1'b1;
                            n_state       = S_WALK;
                        end
                        default: begin
                            n_status = sle_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (w_tok_last.vld) begin
                    n_state = S_OUT;
                    if (r_act == sle_pkg::ACT_FIND) begin
                        if (w_tok_last.hit) begin
                            n_found = w_found_ext[7:0];
                        end else begin
                            n_status = sle_pkg::ST_MISS;
                        end
                    end else begin
                        n_data = w_tok_last.data;
                        if (r_act == sle_pkg::ACT_DELETE) begin
                            n_cmd.op    = sle_pkg::CELL_DELETE;
                            n_cmd.index = r_probe.index;
                            n_cmd.bound = r_count;
                            n_count     = r_count - sle_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cmd    <= '0;
            r_launch <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cmd    <= n_cmd;
            r_launch <= n_launch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe  <= n_probe;
        r_act    <= n_act;
        r_status <= n_status;
        r_data   <= n_data;
        r_found  <= n_found;
    end

    logic [sle_pkg::CMP_W-1:0] w_len;
    assign w_len = sle_pkg::CMP_W'(r_count);

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = (r_state == S_OUT);
    assign o_out.status         = r_status;
    assign o_out.data           = r_data;
    assign o_out.found_position = r_found;
    assign o_out.list_length    = w_len[7:0];

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= w_cap)
        else $error("list length above capacity");

    a_token_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_last.vld |-> r_state == S_WALK)
        else $error("token left the row outside a walk");

    a_launch_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch |-> r_state == S_WALK)
        else $error("token launched outside a walk");

    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.op == sle_pkg::CELL_DELETE |->
            r_count == $past(r_count) - sle_pkg::CNT_W'(1) && r_state == S_OUT)
        else $error("delete without length decrement");

    a_walk_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK && !w_tok_last.vld |=> r_count == $past(r_count))
        else $error("length changed during walk");
`endif

endmodule

>>> verif/list_engine_checker.sv
`timescale 1ns / 1ps
module list_engine_checker
    import sle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sle_in_if    i_in,
    sle_out_if   i_out,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [7:0]         found_position;
        logic [7:0]         list_length;
    } list_reply_t;

    logic signed [31:0] shadow_list [CAPACITY];
    int                 list_len = 0;
    list_reply_t        pending_replies [$];
    int                 mismatches = 0;
    int                 outstanding = 0;
    int                 replies_checked = 0;

    assign o_errors  = mismatches;
    assign o_pending = outstanding;
    assign o_checked = replies_checked;

    function automatic list_reply_t predict_list_op(input logic [2:0] act,
                                                    input logic [7:0] pos,
                                                    input logic signed [31:0] val,
                                                    input logic [7:0] cnt);
        list_reply_t r;
        r = '0;
        case (act)
            ACT_FILL: begin
                if (cnt > CAPACITY) begin
                    r.status = ST_BAD;
                end else begin
                    for (int i = 0; i < cnt; i++) shadow_list[i] = i;
                    list_len = cnt;
                end
            end
            ACT_INSERT: begin
                if (pos == 0 || pos > CAPACITY) begin
                    r.status = ST_BAD;
                end else if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (pos > list_len) begin
                    shadow_list[list_len] = val;
                    list_len++;
                end else begin
                    for (int i = list_len; i >= pos; i--) shadow_list[i] = shadow_list[i - 1];
                    shadow_list[pos - 1] = val;
                    list_len++;
                end
            end
            ACT_DELETE: begin
                if (pos == 0 || pos > list_len) begin
                    r.status = ST_BAD;
                end else begin
                    r.data = shadow_list[pos - 1];
                    for (int i = pos; i < list_len; i++) shadow_list[i - 1] = shadow_list[i];
                    list_len--;
                end
            end
            ACT_FIND: begin
                r.status = ST_MISS;
                for (int i = 0; i < list_len; i++) begin
                    if (shadow_list[i] == val) begin
                        r.found_position = i + 1;
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            ACT_GET: begin
                if (pos == 0 || pos > list_len) r.status = ST_BAD;
                else r.data = shadow_list[pos - 1];
            end
            default: r.status = ST_BAD;
        endcase
        r.list_length = list_len[7:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        list_reply_t want;
        list_reply_t got;
        if (!i_rst_n) begin
            list_len = 0;
            pending_replies.delete();
        end else begin
            // result first: it always belongs to an earlier transfer
            if (i_out.valid && i_out.ready) begin
                got.status         = i_out.status;
                got.data           = i_out.data;
                got.found_position = i_out.found_position;
                got.list_length    = i_out.list_length;
                if (pending_replies.size() == 0) begin
                    $error("result transfer with no item outstanding");
                    mismatches++;
                end else begin
                    want = pending_replies.pop_front();
                    replies_checked++;
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.data !== want.data) begin
                        $error("data: expected %0d, got %0d", want.data, got.data);
                        mismatches++;
                    end
                    if (got.found_position !== want.found_position) begin
                        $error("found_position: expected %0d, got %0d",
                               want.found_position, got.found_position);
                        mismatches++;
                    end
                    if (got.list_length !== want.list_length) begin
                        $error("list_length: expected %0d, got %0d",
                               want.list_length, got.list_length);
                        mismatches++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                pending_replies.push_back(predict_list_op(i_in.action, i_in.position,
                                                          i_in.value, i_in.fill_count));
            end
        end
        outstanding = pending_replies.size();
    end

endmodule

>>> verif/sequential_list_engine_top_tb.sv
`timescale 1ns / 1ps
module sequential_list_engine_top_tb;
    import sle_pkg::*;

    localparam int ACT_CODE_MAX  = 7;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int QUIET_TAIL    = 150;
    localparam int SETTLE_CYCLES = CAPACITY + 16;
    localparam int DRAIN_LIMIT   = 20000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sle_in_if  in_ch ();
    sle_out_if out_ch ();

    int                 mismatches;
    int                 outstanding;
    int                 checked;
    bit                 idle_on = 1'b0;
    int                 stall_left = 0;
    int                 sent_by_act [ACT_CODE_MAX + 1];
    logic [7:0]         length_seen = '0;
    logic signed [31:0] value_pool [8];

    always #4 i_clk = ~i_clk;

    sequential_list_engine_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    list_engine_checker list_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_errors  (mismatches),
        .o_pending (outstanding),
        .o_checked (checked)
    );

    // receiver backpressure in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            out_ch.ready = 1'b0;
            stall_left = $urandom_range(0, 10);
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    // length hint for steering positions
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) length_seen <= out_ch.list_length;
    end

    task automatic send_op(input logic [2:0] act, input logic [7:0] pos,
                           input logic signed [31:0] val, input logic [7:0] cnt);
        @(negedge i_clk);
        in_ch.valid      = 1'b1;
        in_ch.action     = act;
        in_ch.position   = pos;
        in_ch.value      = val;
        in_ch.fill_count = cnt;
        sent_by_act[act]++;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        in_ch.valid      = 1'b0;
        in_ch.action     = $urandom;
        in_ch.position   = $urandom;
        in_ch.value      = $urandom;
        in_ch.fill_count = $urandom;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        hold_off(1);
        while (outstanding != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return value_pool[$urandom_range(0, 7)];
            4, 5, 6:    return $urandom_range(0, CAPACITY - 1);
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_position();
        int span;
        span = int'(length_seen) + 1;
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
        return $urandom_range(1, span);
    endfunction

    function automatic logic [7:0] pick_fill_count();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 16);
            6, 7:             return $urandom_range(0, CAPACITY);
            8:                return $urandom_range(CAPACITY - 4, CAPACITY);
            default:          return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic send_random_op();
        int       roll;
        logic [2:0] act;
        roll = $urandom_range(0, 99);
        if (roll < 7)       act = ACT_FILL;
        else if (roll < 42) act = ACT_INSERT;
        else if (roll < 60) act = ACT_DELETE;
        else if (roll < 75) act = ACT_FIND;
        else if (roll < 93) act = ACT_GET;
        else                act = 3'($urandom_range(int'(ACT_GET) + 1, ACT_CODE_MAX));
        send_op(act, pick_position(), pick_value(), pick_fill_count());
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_FILL;
        in_ch.position   = '0;
        in_ch.value      = '0;
        in_ch.fill_count = '0;
        out_ch.ready     = 1'b1;
        foreach (sent_by_act[k]) sent_by_act[k] = 0;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = -32'sd1;
        value_pool[3] = 32'sd0;
        for (int k = 4; k < 8; k++) value_pool[k] = $urandom;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        idle_on = 1'b1;
        // empty-list errors
        send_op(ACT_GET,    8'd1,   32'sd0, 8'd0);
        send_op(ACT_DELETE, 8'd1,   32'sd0, 8'd0);
        send_op(ACT_FIND,   8'd0,   32'sd0, 8'd0);
        // insert bad positions, append, shifting inserts; then find, get and delete
        send_op(ACT_INSERT, 8'd0,   32'sd5, 8'd0);
        send_op(ACT_INSERT, 8'd255, 32'sd5, 8'd0);
        send_op(ACT_INSERT, 8'(CAPACITY), 32'sh7FFF_FFFF, 8'd0);
        send_op(ACT_INSERT, 8'd1,   32'sh8000_0000, 8'd0);
        send_op(ACT_INSERT, 8'd2,   -32'sd1, 8'd0);
        send_op(ACT_FIND,   8'd0,   32'sh8000_0000, 8'd0);
        send_op(ACT_GET,    8'd3,   32'sd0, 8'd0);
        send_op(ACT_GET,    8'd4,   32'sd0, 8'd0);
        send_op(ACT_DELETE, 8'd2,   32'sd0, 8'd0);
        // undefined actions
        send_op(3'(int'(ACT_GET) + 1), 8'd1, 32'sd0, 8'd1);
        send_op(3'(ACT_CODE_MAX - 1),  8'd1, 32'sd0, 8'd1);
        send_op(3'(ACT_CODE_MAX),      8'd1, 32'sd0, 8'd1);
        // fill limits, full list
        send_op(ACT_FILL,   8'd0,   32'sd0, 8'd255);
        send_op(ACT_FILL,   8'd0,   32'sd0, 8'(CAPACITY + 1));
        send_op(ACT_FILL,   8'd0,   32'sd0, 8'd0);
        send_op(ACT_FILL,   8'd0,   32'sd0, 8'(CAPACITY));
        send_op(ACT_INSERT, 8'd1,   32'sd9, 8'd0);
        send_op(ACT_INSERT, 8'd0,   32'sd9, 8'd0);
        send_op(ACT_FIND,   8'd0,   32'(CAPACITY - 1), 8'd0);
        send_op(ACT_GET,    8'(CAPACITY), 32'sd0, 8'd0);
        send_op(ACT_DELETE, 8'(CAPACITY), 32'sd0, 8'd0);
        send_op(ACT_DELETE, 8'd1,   32'sd0, 8'd0);
        wait_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
            else if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (n == RANDOM_ITEMS / 2) wait_drain();
            if (idle_on && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 11));
            send_random_op();
        end
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Transfers: fill %0d, insert %0d, delete %0d, find %0d, get %0d, undefined %0d",
                 sent_by_act[ACT_FILL], sent_by_act[ACT_INSERT], sent_by_act[ACT_DELETE],
                 sent_by_act[ACT_FIND], sent_by_act[ACT_GET],
                 sent_by_act[5] + sent_by_act[6] + sent_by_act[7]);
        $display("%0d results compared with the predicted list, %0d mismatches, %0d outstanding",
                 checked, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #25_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
